/* rtl/core/lkv_pkg.sv */
// Shared types and codes for the linear key/value table.
package lkv_pkg;

  // Request kinds; the unused code behaves as a find
  typedef enum logic [1:0] {
    KIND_FIND   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SEARCH = 2'd1,
    S_SHIFT  = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [63:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [63:0] read_value;
  } out_t;

  // One stored pair
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
  } entry_t;

  // Port enables between the sequencer and the entry store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

/* rtl/core/lkv_store.sv */
// Entry store: one write port and one registered read port.
module lkv_store #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6
) (
  input  logic               clk,
  input  lkv_pkg::mem_ctl_t  ctl,
  input  logic [AW-1:0]      rd_addr,
  input  logic [AW-1:0]      wr_addr,
  input  lkv_pkg::entry_t    wr_data,
  output lkv_pkg::entry_t    rd_data
);

  lkv_pkg::entry_t mem [CAPACITY];
  lkv_pkg::entry_t rd_data_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry, data valid the next cycle
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/linear_key_value_table.sv */
// Top level of the linear key/value table: search and compaction sequencer.
//
// A request is taken when start is high and busy is low; busy then stays high
// until the walk is done, and the single result shows for one cycle on
// out_valid/out_item right after busy falls, which the receiver must take at
// once. The next request can be taken at the edge that ends the result cycle.
// Each request walks the stored entries one per cycle through the single read
// port of the entry store and the one 64-bit key comparator. The search ends
// at the first hit or after the last stored entry. A delete that hits then
// moves the later entries down, one move per cycle through the same read
// port and the write port. With a full table of CAPACITY entries the worst
// case is a delete that hits entry 0.
module linear_key_value_table #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  lkv_pkg::in_t  in_item,
  output logic          out_valid,
  output lkv_pkg::out_t out_item
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  lkv_pkg::state_t   state_r, state_nxt;
  lkv_pkg::in_t      req_r, req_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     scan_r, scan_nxt;
  logic [CW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [CW-1:0]     dst_r, dst_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic              out_valid_r, out_valid_nxt;
  lkv_pkg::out_t     out_item_r, out_item_nxt;

  lkv_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  lkv_pkg::entry_t   wr_data;
  lkv_pkg::entry_t   rd_data;

  logic issue;
  logic hit;
  logic miss;
  logic is_insert;
  logic is_delete;

  lkv_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Walk status shared by search and shift
  assign issue     = (scan_r < count_r);
  assign hit       = cmp_vld_r && (rd_data.key == req_r.key);
  assign miss      = !cmp_vld_r && !issue;
  assign is_insert = (req_r.kind == lkv_pkg::KIND_INSERT);
  assign is_delete = (req_r.kind == lkv_pkg::KIND_DELETE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lkv_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = lkv_pkg::S_SEARCH;
        end
      end
      lkv_pkg::S_SEARCH: begin
        if (hit && is_delete) begin
          state_nxt = lkv_pkg::S_SHIFT;
        end else if (hit || miss) begin
          state_nxt = lkv_pkg::S_IDLE;
        end
      end
      lkv_pkg::S_SHIFT: begin
        if (!issue && !cmp_vld_r) begin
          state_nxt = lkv_pkg::S_IDLE;
        end
      end
      default: state_nxt = lkv_pkg::S_IDLE;
    endcase
  end

  // Datapath, store control and result
  always_comb begin
    req_nxt       = req_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    cmp_idx_nxt   = cmp_idx_r;
    dst_nxt       = dst_r;
    cmp_vld_nxt   = 1'b0;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_ctl       = '0;
    rd_addr       = scan_r[AW-1:0];
    wr_addr       = count_r[AW-1:0];
    wr_data       = '{key: req_r.key, value: req_r.value};
    case (state_r)
      lkv_pkg::S_IDLE: begin
        // Capture the request and restart the walk
        if (start) begin
          req_nxt  = in_item;
          scan_nxt = '0;
        end
      end
      lkv_pkg::S_SEARCH: begin
        // Issue the next read, compare the one returned
        mem_ctl.rd_en = issue;
        scan_nxt      = scan_r + CW'(issue);
        cmp_vld_nxt   = issue;
        cmp_idx_nxt   = scan_r;
        out_item_nxt  = '{status: lkv_pkg::ST_OK, found: hit, read_value: 64'd0};
        if (hit) begin
          if (is_insert) begin
            out_item_nxt.status = lkv_pkg::ST_DUPLICATE;
            out_valid_nxt       = 1'b1;
          end else if (is_delete) begin
            // Start moving entries above the hit down by one
            scan_nxt    = cmp_idx_r + CW'(1);
            dst_nxt     = cmp_idx_r;
            cmp_vld_nxt = 1'b0;
          end else begin
            out_item_nxt.read_value = rd_data.value;
            out_valid_nxt           = 1'b1;
          end
        end else if (miss) begin
          out_valid_nxt = 1'b1;
          if (is_insert) begin
            if (count_r >= CW'(CAPACITY)) begin
              out_item_nxt.status = lkv_pkg::ST_FULL;
            end else begin
              // Append at the end of the list
              mem_ctl.wr_en = 1'b1;
              count_nxt     = count_r + CW'(1);
            end
          end else if (is_delete) begin
            out_item_nxt.status = lkv_pkg::ST_NOT_FOUND;
          end
        end
      end
      lkv_pkg::S_SHIFT: begin
        // Read entry above, write it one place down next cycle
        mem_ctl.rd_en = issue;
        scan_nxt      = scan_r + CW'(issue);
        cmp_vld_nxt   = issue;
        wr_addr       = dst_r[AW-1:0];
        wr_data       = rd_data;
        if (cmp_vld_r) begin
          mem_ctl.wr_en = 1'b1;
          dst_nxt       = dst_r + CW'(1);
        end
        if (!issue && !cmp_vld_r) begin
          count_nxt     = count_r - CW'(1);
          out_item_nxt  = '{status: lkv_pkg::ST_OK, found: 1'b1, read_value: 64'd0};
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkv_pkg::S_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    scan_r     <= scan_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    dst_r      <= dst_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != lkv_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* tb/tb_linear_key_value_table.sv */
// Self-checking testbench for the linear key/value table: find, insert and delete transfers.
module tb_linear_key_value_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY   = 64;
  localparam int POOL_SIZE  = 96;
  localparam int SETTLE     = 2 * CAPACITY + 8;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ALT_A    = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] ALT_5    = 64'h5555_5555_5555_5555;
  localparam logic [63:0] TOP_BIT  = 64'h8000_0000_0000_0000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  lkv_pkg::in_t  in_item = '0;
  logic          out_valid;
  lkv_pkg::out_t out_item;

  // Predicted table contents
  logic [63:0] tbl_keys [CAPACITY];
  logic [63:0] tbl_vals [CAPACITY];
  int          tbl_count = 0;

  // Expected responses, oldest first
  lkv_pkg::out_t pending_resp [$];
  int            mismatches = 0;

  // Keys reused across requests so that hits and duplicates are common
  logic [63:0] key_pool [POOL_SIZE];

  linear_key_value_table #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Apply one request to the predicted table and form its response
  task automatic table_step(input lkv_pkg::in_t req, output lkv_pkg::out_t resp);
    logic hit;
    int   pos;
    hit = 1'b0;
    pos = 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (!hit && tbl_keys[i] == req.key) begin
        hit = 1'b1;
        pos = i;
      end
    end
    resp.status     = lkv_pkg::ST_OK;
    resp.found      = hit;
    resp.read_value = '0;
    if (req.kind == lkv_pkg::KIND_INSERT) begin
      if (hit) begin
        resp.status = lkv_pkg::ST_DUPLICATE;
      end else if (tbl_count >= CAPACITY) begin
        resp.status = lkv_pkg::ST_FULL;
      end else begin
        tbl_keys[tbl_count] = req.key;
        tbl_vals[tbl_count] = req.value;
        tbl_count++;
      end
    end else if (req.kind == lkv_pkg::KIND_DELETE) begin
      if (!hit) begin
        resp.status = lkv_pkg::ST_NOT_FOUND;
      end else begin
        // close the gap, keeping insertion order
        for (int i = pos; i + 1 < tbl_count; i++) begin
          tbl_keys[i] = tbl_keys[i + 1];
          tbl_vals[i] = tbl_vals[i + 1];
        end
        tbl_count--;
      end
    end else if (hit) begin
      resp.read_value = tbl_vals[pos];
    end
  endtask

  // Drive one request and hold it until the table takes it
  task automatic send_req(input lkv_pkg::kind_t kind, input logic [63:0] key,
                          input logic [63:0] value);
    lkv_pkg::in_t  req;
    lkv_pkg::out_t resp;
    req.kind  = kind;
    req.key   = key;
    req.value = value;
    in_item <= req;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    table_step(req, resp);
    pending_resp.push_back(resp);
  endtask

  // Idle the sender for a random number of cycles
  task automatic sender_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold off new requests until every response is back
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
  endtask

  // Check each response against the oldest expectation
  always @(posedge clk) begin
    lkv_pkg::out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_resp.size() == 0) begin
        $error("unexpected response: status %0d found %0d read_value %h",
               out_item.status, out_item.found, out_item.read_value);
        mismatches++;
      end else begin
        want = pending_resp.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          mismatches++;
        end
        if (out_item.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_item.found);
          mismatches++;
        end
        if (out_item.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, out_item.read_value);
          mismatches++;
        end
      end
    end
  end

  // Empty-table cases, field extremes, every kind, hits at first, middle and last place
  task automatic test_directed();
    send_req(lkv_pkg::KIND_FIND, '0, ALL_ONES);
    send_req(lkv_pkg::KIND_DELETE, ALL_ONES, '0);
    send_req(lkv_pkg::KIND_SPARE, '0, ALT_A);
    send_req(lkv_pkg::KIND_INSERT, '0, ALL_ONES);
    send_req(lkv_pkg::KIND_INSERT, ALL_ONES, '0);
    send_req(lkv_pkg::KIND_INSERT, '0, ALT_5);
    send_req(lkv_pkg::KIND_FIND, '0, '0);
    send_req(lkv_pkg::KIND_FIND, ALL_ONES, ALL_ONES);
    send_req(lkv_pkg::KIND_SPARE, ALL_ONES, '0);
    send_req(lkv_pkg::KIND_SPARE, '0, ALL_ONES);
    send_req(lkv_pkg::KIND_INSERT, ALT_5, ALT_A);
    send_req(lkv_pkg::KIND_INSERT, ALT_A, ALT_5);
    send_req(lkv_pkg::KIND_DELETE, '0, ALL_ONES);
    send_req(lkv_pkg::KIND_FIND, ALL_ONES, '0);
    send_req(lkv_pkg::KIND_FIND, ALT_A, '0);
    send_req(lkv_pkg::KIND_DELETE, ALT_A, '0);
    send_req(lkv_pkg::KIND_INSERT, TOP_BIT, 64'd1);
    send_req(lkv_pkg::KIND_DELETE, ALT_5, '0);
    send_req(lkv_pkg::KIND_FIND, TOP_BIT, ALT_5);
    send_req(lkv_pkg::KIND_DELETE, '0, '0);
    send_req(lkv_pkg::KIND_FIND, ALT_5, '0);
    send_req(lkv_pkg::KIND_INSERT, ALT_5, TOP_BIT);
    send_req(lkv_pkg::KIND_FIND, ALT_5, '0);
    wait_drained();
  endtask

  // Fill to capacity, probe the full table, then empty it in random order
  task automatic test_full_table();
    logic [63:0] k;
    while (tbl_count < CAPACITY) begin
      send_req(lkv_pkg::KIND_INSERT, rand_word(), rand_word());
      sender_gap(27);
    end
    wait_drained();
    send_req(lkv_pkg::KIND_INSERT, rand_word(), rand_word());
    send_req(lkv_pkg::KIND_INSERT, tbl_keys[CAPACITY - 1], rand_word());
    send_req(lkv_pkg::KIND_FIND, tbl_keys[CAPACITY - 1], rand_word());
    send_req(lkv_pkg::KIND_FIND, rand_word(), '0);
    send_req(lkv_pkg::KIND_DELETE, tbl_keys[0], '0);
    send_req(lkv_pkg::KIND_INSERT, ALL_ONES, ALL_ONES);
    send_req(lkv_pkg::KIND_FIND, ALL_ONES, '0);
    send_req(lkv_pkg::KIND_DELETE, tbl_keys[CAPACITY - 1], '0);
    while (tbl_count > 0) begin
      k = tbl_keys[$urandom_range(tbl_count - 1)];
      send_req(lkv_pkg::KIND_DELETE, k, rand_word());
      sender_gap(27);
    end
    send_req(lkv_pkg::KIND_FIND, k, '0);
  endtask

  // Random mix in bursts that push the fill level up and down
  task automatic test_random(input int gap_pct, input int n_reqs);
    int              insert_pct;
    int              pick;
    lkv_pkg::kind_t  kind;
    logic [63:0]     key;
    insert_pct = 50;
    for (int n = 0; n < n_reqs; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 20;
          1: insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      pick = $urandom_range(99);
      if (pick < insert_pct) begin
        kind = lkv_pkg::KIND_INSERT;
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3: kind = lkv_pkg::KIND_FIND;
          4, 5, 6, 7, 8: kind = lkv_pkg::KIND_DELETE;
          default: kind = lkv_pkg::KIND_SPARE;
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 40 && tbl_count > 0) begin
        key = tbl_keys[$urandom_range(tbl_count - 1)];
      end else if (pick < 85) begin
        key = key_pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
        key = rand_word();
      end
      send_req(kind, key, rand_word());
      sender_gap(gap_pct);
    end
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = rand_word();
    end
    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_table();
    test_random(27, 580);
    test_random(56, 580);
    test_random(0, 590);

    // let the last responses arrive, then watch for stray ones
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/lkv_pkg.sv
rtl/core/lkv_store.sv
rtl/core/linear_key_value_table.sv
tb/tb_linear_key_value_table.sv
